@@ src/ial_pkg.sv @@
// Shared types and constants for the indexed array list engine.
// Used by ial_store, ial_ctrl and indexed_array_list_engine; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ial_pkg;

    localparam int DEPTH     = 64;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int DATA_W    = 32;
    localparam int FUNC_W    = 3;
    localparam int POS_W     = 7;
    localparam int FOUND_W   = 6;
    localparam int COUNT_W   = 7;
    localparam int CW        = (POS_W > CNT_W) ? POS_W : CNT_W;

    typedef enum logic [FUNC_W-1:0] {
        F_CLEAR  = 3'd0,
        F_INSERT = 3'd1,
        F_DELETE = 3'd2,
        F_SEARCH = 3'd3,
        F_READ   = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_READ
    } t_state;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr;
    } t_mem_req;

    typedef struct packed {
        logic              valid;
        t_status           status;
        logic [IDX_W-1:0]  found;
        logic [DATA_W-1:0] rd;
        logic [CNT_W-1:0]  count;
    } t_result;

endpackage

`default_nettype wire

@@ src/ial_store.sv @@
// List storage: one write port and one registered read port.
// Depends on ial_pkg for the depth and the request struct.
`timescale 1ns / 1ps
`default_nettype none

module ial_store
    import ial_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_mem_req          i_req,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_req.raddr];
    end

endmodule

`default_nettype wire

@@ src/ial_ctrl.sv @@
// Sequencer for the list operations: scans, shifts and compares one entry at a time.
// Depends on ial_pkg; drives the storage request and the result registers.
`timescale 1ns / 1ps
`default_nettype none

module ial_ctrl
    import ial_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [FUNC_W-1:0] i_func,
    input  wire logic [POS_W-1:0]  i_position,
    input  wire logic [DATA_W-1:0] i_data_value,
    input  wire logic [DATA_W-1:0] i_rdata,
    output t_mem_req               o_mem,
    output logic                   o_busy,
    output t_result                o_res
);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_ptr,   n_ptr;
    logic [IDX_W-1:0]  r_found, n_found;
    logic [POS_W-1:0]  r_pos,   n_pos;
    logic [DATA_W-1:0] r_val,   n_val;
    t_func             r_func,  n_func;
    logic              r_valid, n_valid;
    t_status           r_status, n_status;
    logic [IDX_W-1:0]  r_res_found, n_res_found;
    logic [DATA_W-1:0] r_rd,    n_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr       <= n_ptr;
        r_found     <= n_found;
        r_pos       <= n_pos;
        r_val       <= n_val;
        r_func      <= n_func;
        r_status    <= n_status;
        r_res_found <= n_res_found;
        r_rd        <= n_rd;
    end

    always_comb begin
        logic [CNT_W-1:0] ptr_inc;
        ptr_inc     = r_ptr + CNT_W'(1);
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_found     = r_found;
        n_pos       = r_pos;
        n_val       = r_val;
        n_func      = r_func;
        n_valid     = 1'b0;
        n_status    = r_status;
        n_res_found = r_res_found;
        n_rd        = r_rd;
        o_mem.we    = 1'b0;
        o_mem.waddr = IDX_W'(r_ptr);
        o_mem.wdata = i_rdata;
        o_mem.raddr = IDX_W'(r_ptr);

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_pos       = i_position;
                    n_val       = i_data_value;
                    n_func      = t_func'(i_func);
                    n_res_found = '0;
                    n_rd        = '0;
                    unique case (t_func'(i_func))
                        F_CLEAR: begin
                            n_count  = '0;
                            n_valid  = 1'b1;
                            n_status = ST_OK;
                        end
                        F_INSERT: begin
                            if (CW'(i_position) > CW'(r_count) ||
                                32'(r_count) >= DEPTH) begin
                                n_valid  = 1'b1;
                                n_status = ST_INVALID;
                            end else begin
                                n_ptr   = r_count;
                                n_state = S_INS_RD;
                            end
                        end
                        F_DELETE, F_SEARCH: begin
                            if (r_count == '0) begin
                                n_valid  = 1'b1;
                                n_status = ST_NOT_FOUND;
                            end else begin
                                n_ptr   = '0;
                                n_state = S_SCAN_RD;
                            end
                        end
                        F_READ: begin
                            if (CW'(i_position) < CW'(r_count)) begin
                                o_mem.raddr = IDX_W'(i_position);
                                n_state     = S_READ;
                            end else begin
                                n_valid  = 1'b1;
                                n_status = ST_INVALID;
                            end
                        end
                        default: begin
                            n_valid  = 1'b1;
                            n_status = ST_INVALID;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_valid  = 1'b1;
                n_status = ST_OK;
                n_rd     = i_rdata;
                n_state  = S_IDLE;
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (i_rdata == r_val) begin
                    n_found = IDX_W'(r_ptr);
                    if (r_func == F_DELETE) begin
                        n_state = S_DEL_RD;
                    end else begin
                        n_valid     = 1'b1;
                        n_status    = ST_OK;
                        n_res_found = IDX_W'(r_ptr);
                        n_state     = S_IDLE;
                    end
                end else if (ptr_inc == r_count) begin
                    n_valid  = 1'b1;
                    n_status = ST_NOT_FOUND;
                    n_state  = S_IDLE;
                end else begin
                    n_ptr   = ptr_inc;
                    n_state = S_SCAN_RD;
                end
            end
            S_DEL_RD: begin
                // Pull the next entry down until the tail is reached.
                if (ptr_inc >= r_count) begin
                    n_count     = r_count - CNT_W'(1);
                    n_valid     = 1'b1;
                    n_status    = ST_OK;
                    n_res_found = r_found;
                    n_state     = S_IDLE;
                end else begin
                    o_mem.raddr = IDX_W'(ptr_inc);
                    n_state     = S_DEL_WR;
                end
            end
            S_DEL_WR: begin
                o_mem.we = 1'b1;
                n_ptr    = ptr_inc;
                n_state  = S_DEL_RD;
            end
            S_INS_RD: begin
                // Move entries up from the tail until the gap reaches the position.
                if (CW'(r_ptr) == CW'(r_pos)) begin
                    o_mem.we    = 1'b1;
                    o_mem.wdata = r_val;
                    n_count     = r_count + CNT_W'(1);
                    n_valid     = 1'b1;
                    n_status    = ST_OK;
                    n_state     = S_IDLE;
                end else begin
                    o_mem.raddr = IDX_W'(r_ptr - CNT_W'(1));
                    n_state     = S_INS_WR;
                end
            end
            S_INS_WR: begin
                o_mem.we = 1'b1;
                n_ptr    = r_ptr - CNT_W'(1);
                n_state  = S_INS_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_res.valid  = r_valid;
    assign o_res.status = r_status;
    assign o_res.found  = r_res_found;
    assign o_res.rd     = r_rd;
    assign o_res.count  = r_count;

endmodule

`default_nettype wire

@@ src/indexed_array_list_engine.sv @@
// Top level of the indexed array list engine: sequencer plus list storage.
// Depends on ial_pkg, ial_ctrl and ial_store.
// Clear and rejected requests are answered from idle; a read passes through S_READ; a search
// alternates S_SCAN_RD and S_SCAN_CMP per entry; delete and insert move each entry by a read and a write.
// Throughput is one request per operation; the single storage read port sets the pace.
// Reset clears the count and the sequencer; storage contents stay undefined until written.
// The receiver cannot stall: each result shows for one cycle on o_valid.
`timescale 1ns / 1ps
`default_nettype none

module indexed_array_list_engine
    import ial_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    input  wire logic        [FUNC_W-1:0] i_func,
    input  wire logic        [POS_W-1:0]  i_position,
    input  wire logic signed [DATA_W-1:0] i_data_value,
    output logic                          busy,
    output logic                          o_valid,
    output logic             [1:0]        o_status,
    output logic             [FOUND_W-1:0] o_found_index,
    output logic signed      [DATA_W-1:0] o_read_value,
    output logic             [COUNT_W-1:0] o_entry_count
);

    // The storage request comes from the sequencer; read data returns in the following cycle.
    t_mem_req          mem_req;
    logic [DATA_W-1:0] mem_rdata;
    t_result           res;

    ial_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_func       (i_func),
        .i_position   (i_position),
        .i_data_value (i_data_value),
        .i_rdata      (mem_rdata),
        .o_mem        (mem_req),
        .o_busy       (busy),
        .o_res        (res)
    );

    ial_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // Result fields are sized to the port widths; wider indexes are masked.
    assign o_valid       = res.valid;
    assign o_status      = res.status;
    assign o_found_index = FOUND_W'(res.found);
    assign o_read_value  = res.rd;
    assign o_entry_count = COUNT_W'(res.count);

    // The sequencer only returns to idle by delivering a result.
    a_busy_ends_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy dropped without a result");

    // A clear taken from idle answers at once with an empty list.
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == F_CLEAR) |=> (o_valid && o_entry_count == '0))
        else $error("clear did not empty the list");

    // The count never exceeds the storage depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_entry_count) <= DEPTH))
        else $error("entry count beyond depth");

    // A failed lookup reports no index and no data.
    a_not_found_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_NOT_FOUND) |-> (o_found_index == '0 && o_read_value == '0))
        else $error("not-found result carries stale fields");

endmodule

`default_nettype wire
